FILE: rtl/core/msbp_pkg.sv
// shared constants and types for the msb-first bit packer
package msbp_pkg;

  localparam int unsigned BYTE_BITS = 8;
  localparam int unsigned PEND_BITS = 7;
  localparam int unsigned USED_W    = 3;
  localparam int unsigned NEED_W    = 4;

  // input action codes
  localparam logic ACTION_SEND  = 1'b0;
  localparam logic ACTION_FLUSH = 1'b1;

  // queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } msbp_q_stat_t;

endpackage

FILE: rtl/core/msb_first_bit_packer_core.sv
// top level of the msb-first variable-length bit packer
// A send transfer appends the low in_bit_count bits of in_code_value (counts above
// MAX_CODE_BITS saturate, a count of zero does nothing) to up to seven pending bits,
// and every byte that fills leaves on the out channel with its earliest bit in bit 7;
// a flush transfer pads the pending bits with zeros and sends that byte if any bits
// were waiting. out_last_of_run marks the final byte caused by one input transfer.
// Inputs pass through a two-entry queue to a packing engine that closes one byte per
// cycle while the output register can take it: a send is loaded and left-aligned, each
// completed byte goes out, and leftover bits move into the pending register; a flush
// acts when popped. The engine runs as long as the byte output register can be refilled.
module msb_first_bit_packer_core #(
  parameter int unsigned MAX_CODE_BITS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [63:0] in_code_value,
  input  logic [6:0]  in_bit_count,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last_of_run
);

  // queue entry: flush flag, saturated count, low code bits
  localparam int unsigned CNT_W  = $clog2(MAX_CODE_BITS + 1);
  localparam int unsigned DATA_W = 1 + CNT_W + MAX_CODE_BITS;

  msbp_pkg::msbp_q_stat_t q_stat;
  logic                   push;
  logic [DATA_W-1:0]      push_data;
  logic                   pop;
  logic [DATA_W-1:0]      pop_data;

  // classify and filter incoming transfers
  msbp_front #(
    .MAX_CODE_BITS (MAX_CODE_BITS),
    .CNT_W         (CNT_W),
    .DATA_W        (DATA_W)
  ) u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_code_value (in_code_value),
    .in_bit_count  (in_bit_count),
    .q_stat        (q_stat),
    .push          (push),
    .push_data     (push_data)
  );

  // decouples acceptance from byte production
  msbp_fifo #(
    .DATA_W (DATA_W)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  // pending register and byte engine, registered output
  msbp_back #(
    .MAX_CODE_BITS (MAX_CODE_BITS),
    .CNT_W         (CNT_W),
    .DATA_W        (DATA_W)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_stat          (q_stat),
    .pop_data        (pop_data),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run)
  );

endmodule

FILE: rtl/core/msbp_front.sv
// front end: accepts input transfers, drops empty sends, saturates the count
module msbp_front #(
  parameter int unsigned MAX_CODE_BITS = 64,
  parameter int unsigned CNT_W         = $clog2(MAX_CODE_BITS + 1),
  parameter int unsigned DATA_W        = 1 + CNT_W + MAX_CODE_BITS
) (
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_action,
  input  logic [63:0]          in_code_value,
  input  logic [6:0]           in_bit_count,
  input  msbp_pkg::msbp_q_stat_t q_stat,
  output logic                 push,
  output logic [DATA_W-1:0]    push_data
);

  logic             accept;
  logic             is_flush;
  logic [CNT_W-1:0] sat_count;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign is_flush = (in_action == msbp_pkg::ACTION_FLUSH);

  always_comb begin
    if (in_bit_count > 7'(MAX_CODE_BITS)) begin
      sat_count = CNT_W'(MAX_CODE_BITS);
    end else begin
      sat_count = CNT_W'(in_bit_count);
    end
  end

  // a send of zero bits never reaches the queue
  assign push      = accept && (is_flush || (in_bit_count != 7'd0));
  assign push_data = {is_flush, sat_count, in_code_value[MAX_CODE_BITS-1:0]};

endmodule

FILE: rtl/core/msbp_fifo.sv
// two-entry queue between the front and the back
module msbp_fifo #(
  parameter int unsigned DATA_W = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  logic [DATA_W-1:0]      push_data,
  input  logic                   pop,
  output logic [DATA_W-1:0]      pop_data,
  output msbp_pkg::msbp_q_stat_t q_stat
);

  logic [DATA_W-1:0] mem_r [2];
  logic              wr_ptr_r, wr_ptr_nxt;
  logic              rd_ptr_r, rd_ptr_nxt;
  logic [1:0]        cnt_r, cnt_nxt;

  assign q_stat.full  = (cnt_r == 2'd2);
  assign q_stat.empty = (cnt_r == 2'd0);
  assign pop_data     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/core/msbp_back.sv
// back end: packs queued codes into bytes, one byte per cycle while the output slot is free
module msbp_back #(
  parameter int unsigned MAX_CODE_BITS = 64,
  parameter int unsigned CNT_W         = $clog2(MAX_CODE_BITS + 1),
  parameter int unsigned DATA_W        = 1 + CNT_W + MAX_CODE_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  msbp_pkg::msbp_q_stat_t q_stat,
  input  logic [DATA_W-1:0]      pop_data,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             out_byte,
  output logic                   out_last_of_run
);

  localparam int unsigned W = MAX_CODE_BITS;

  logic                         q_flush;
  logic [CNT_W-1:0]             q_count;
  logic [W-1:0]                 q_code;

  logic                         busy_r, busy_nxt;
  logic [W-1:0]                 aligned_r, aligned_nxt;
  logic [CNT_W-1:0]             rem_r, rem_nxt;
  logic [msbp_pkg::PEND_BITS-1:0] acc_r, acc_nxt;
  logic [msbp_pkg::USED_W-1:0]  used_r, used_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [7:0]                   out_byte_r, out_byte_nxt;
  logic                         out_last_r, out_last_nxt;

  logic                         slot_free;
  logic [msbp_pkg::NEED_W-1:0]  need;
  logic [CNT_W-1:0]             need_c;
  logic [7:0]                   top8;
  logic [7:0]                   acc_hi;
  logic [CNT_W-1:0]             shamt;

  assign {q_flush, q_count, q_code} = pop_data;

  assign slot_free = !out_valid_r || out_ready;
  assign need      = msbp_pkg::NEED_W'(msbp_pkg::BYTE_BITS) - {1'b0, used_r};
  assign need_c    = CNT_W'(need);
  assign top8      = aligned_r[W-1 -: 8];
  // pending bits moved up to the top of a byte
  assign acc_hi    = 8'({1'b0, acc_r} << need);
  assign shamt     = CNT_W'(W) - q_count;

  always_comb begin
    busy_nxt      = busy_r;
    aligned_nxt   = aligned_r;
    rem_nxt       = rem_r;
    acc_nxt       = acc_r;
    used_nxt      = used_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    pop           = 1'b0;

    if (busy_r) begin
      if (slot_free) begin
        if (rem_r >= need_c) begin
          // enough bits to close a byte
          out_valid_nxt = 1'b1;
          out_byte_nxt  = acc_hi | (top8 >> used_r);
          out_last_nxt  = ((rem_r - need_c) < CNT_W'(msbp_pkg::BYTE_BITS));
          rem_nxt       = rem_r - need_c;
          aligned_nxt   = aligned_r << need;
          acc_nxt       = '0;
          used_nxt      = '0;
          busy_nxt      = (rem_r != need_c);
        end else begin
          // leftover bits go to the pending register
          acc_nxt  = msbp_pkg::PEND_BITS'(({1'b0, acc_r} << rem_r)
                     | (top8 >> (CNT_W'(msbp_pkg::BYTE_BITS) - rem_r)));
          used_nxt = used_r + msbp_pkg::USED_W'(rem_r);
          busy_nxt = 1'b0;
        end
      end
    end else if (!q_stat.empty && slot_free) begin
      pop = 1'b1;
      if (q_flush) begin
        if (used_r != '0) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = acc_hi;
          out_last_nxt  = 1'b1;
        end
        acc_nxt  = '0;
        used_nxt = '0;
      end else begin
        // left-align the code so its first bit sits at the top
        aligned_nxt = q_code << shamt;
        rem_nxt     = q_count;
        busy_nxt    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      acc_r       <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      acc_r       <= acc_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    aligned_r  <= aligned_nxt;
    rem_r      <= rem_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_last_of_run = out_last_r;

endmodule
